// ----- sv/paa_pkg.sv -----
// ----------------------------------------------------------------------------
// paa_pkg
// Shared types and constants for the priority arbiter with aging.
// ----------------------------------------------------------------------------
package paa_pkg;

    // Number of arbitrated entries (2 to 16).
    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int PTR_W   = $clog2(ENTRIES + 1);

    // Item function codes.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_ARB  = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_AGE_LIMIT = 1'b0;
    localparam logic CFG_PRIO_CAP  = 1'b1;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [PTR_W-1:0]   t_ptr;
    typedef logic [ENTRIES-1:0] t_mask;

    // One entry as held in the state memory.
    typedef struct packed {
        logic [7:0] prio;
        logic [7:0] wcnt;
    } t_entry;

    typedef struct packed {
        logic [7:0] age_limit;
        logic [7:0] prio_cap;
    } t_cfg;

    typedef struct packed {
        logic       found;
        t_idx       index;
        logic [7:0] prio;
    } t_result;

endpackage

// ----- sv/paa_ram.sv -----
// ----------------------------------------------------------------------------
// paa_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module paa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/paa_seq.sv -----
// ----------------------------------------------------------------------------
// paa_seq
// Entry-walking sequencer: scan pass picks the winner, update pass ages.
// ----------------------------------------------------------------------------
module paa_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_func,
    input  logic [3:0]         i_entry_index,
    input  logic [7:0]         i_load_priority,
    input  logic [15:0]        i_ready_mask,
    input  paa_pkg::t_cfg      i_cfg,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output paa_pkg::t_result   o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPD,
        S_DONE
    } t_state;

    t_state             r_state;
    paa_pkg::t_ptr      r_ptr;
    paa_pkg::t_mask     r_ready;
    paa_pkg::t_mask     r_vld;      // entry written since reset
    logic               r_cmp_en;
    paa_pkg::t_idx      r_cmp_idx;
    logic               r_rd_vld;
    logic               r_found;
    paa_pkg::t_idx      r_win;
    logic [7:0]         r_best;

    logic               accept;
    logic               issue;
    paa_pkg::t_idx      ptr_idx;
    logic               ptr_end;
    logic [15:0]        rd_raw;
    paa_pkg::t_entry    rd_entry;
    logic               hit;
    logic [7:0]         wcnt_inc;
    paa_pkg::t_entry    upd_entry;
    logic               load_we;
    logic               upd_we;
    logic               wr_en;
    paa_pkg::t_idx      wr_addr;
    paa_pkg::t_entry    wr_data;

    assign accept  = i_valid && o_ready;
    assign ptr_idx = r_ptr[paa_pkg::IDX_W-1:0];
    assign ptr_end = (r_ptr == paa_pkg::t_ptr'(paa_pkg::ENTRIES));
    assign issue   = ((r_state == S_SCAN) || (r_state == S_UPD)) && !ptr_end;

    // Never-written entries read as zero.
    assign rd_entry = r_rd_vld ? paa_pkg::t_entry'(rd_raw) : '0;

    // Strictly greater keeps the lowest index on a tie.
    assign hit = r_cmp_en && r_ready[r_cmp_idx] &&
                 (!r_found || (rd_entry.prio > r_best));

    assign wcnt_inc = rd_entry.wcnt + 8'd1;

    always_comb begin
        upd_entry = rd_entry;
        if (r_cmp_idx == r_win) begin
            upd_entry.wcnt = 8'd0;
        end else if (wcnt_inc >= i_cfg.age_limit) begin
            if (rd_entry.prio < i_cfg.prio_cap) begin
                upd_entry.prio = rd_entry.prio + 8'd1;
            end
            upd_entry.wcnt = 8'd0;
        end else begin
            upd_entry.wcnt = wcnt_inc;
        end
    end

    assign load_we = accept && (i_func == paa_pkg::FUNC_LOAD) &&
                     (32'(i_entry_index) < paa_pkg::ENTRIES);
    assign upd_we  = (r_state == S_UPD) && r_cmp_en && r_ready[r_cmp_idx];
    assign wr_en   = load_we || upd_we;

    always_comb begin
        if (upd_we) begin
            wr_addr = r_cmp_idx;
            wr_data = upd_entry;
        end else begin
            wr_addr = paa_pkg::t_idx'(i_entry_index);
            wr_data = '{prio: i_load_priority, wcnt: 8'd0};
        end
    end

    paa_ram #(
        .WIDTH ($bits(paa_pkg::t_entry)),
        .DEPTH (paa_pkg::ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (issue),
        .i_raddr (ptr_idx),
        .o_rdata (rd_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ptr    <= '0;
            r_vld    <= '0;
            r_cmp_en <= 1'b0;
            r_found  <= 1'b0;
            r_win    <= '0;
        end else begin
            r_cmp_en  <= issue;
            r_cmp_idx <= ptr_idx;
            r_rd_vld  <= r_vld[ptr_idx];
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_found <= 1'b0;
                        r_win   <= '0;
                        r_best  <= 8'd0;
                        r_ptr   <= '0;
                        r_ready <= paa_pkg::t_mask'(i_ready_mask);
                        if (i_func == paa_pkg::FUNC_LOAD) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        r_found <= 1'b1;
                        r_win   <= r_cmp_idx;
                        r_best  <= rd_entry.prio;
                    end
                    if (ptr_end) begin
                        r_ptr   <= '0;
                        r_state <= (r_found || hit) ? S_UPD : S_DONE;
                    end else begin
                        r_ptr <= r_ptr + paa_pkg::t_ptr'(1);
                    end
                end
                S_UPD: begin
                    if (ptr_end) begin
                        r_state <= S_DONE;
                    end else begin
                        r_ptr <= r_ptr + paa_pkg::t_ptr'(1);
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = '{found: r_found,
                           index: r_found ? r_win : '0,
                           prio:  r_found ? r_best : 8'd0};

    // A reported winner was ready in the arbitrate beat.
    a_win_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && r_found) |-> r_ready[r_win])
        else $error("winner not in ready mask");

    // The scan pass only reads the memory.
    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !wr_en)
        else $error("memory write during scan");

    // Pointer never runs past the end marker.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= paa_pkg::t_ptr'(paa_pkg::ENTRIES))
        else $error("walk pointer out of range");

    // Reset leaves every entry reading as zero.
    a_vld_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("valid bits not cleared by reset");

endmodule

// ----- sv/priority_arbiter_with_aging.sv -----
// ----------------------------------------------------------------------------
// priority_arbiter_with_aging
// Priority arbiter over per-entry priorities that rise while entries wait.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one beat per item. A load
//   beat (i_func = 0) writes one entry's priority and clears its wait count;
//   an arbitrate beat (i_func = 1) grants the ready entry with the highest
//   priority (lowest index on a tie) and ages the other ready entries.
//   Output channel (o_out_valid / i_out_ready) returns exactly one beat per
//   input beat, in order; a load beat returns an all-zero result.
//   A load goes from idle straight to the done state. An arbitrate item
//   walks the entry memory one entry per cycle on its single read port: a
//   scan pass, then a read-modify-write pass only when some entry is ready.
//   One item is in work at a time; the next beat is taken once the result
//   has left the sequencer. The output register parts the two sides: a new
//   item is accepted while a finished result still waits for i_out_ready.
//   If the receiver stalls with the register full, the next result waits
//   in the sequencer and input is held off.
//   Reset (synchronous, active low) clears all priorities and wait counts
//   (via per-entry valid bits, no clearing pass) and sets the age limit to
//   5 and the priority ceiling to 255. Configuration writes only while idle.
// ----------------------------------------------------------------------------
module priority_arbiter_with_aging (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [3:0]  i_entry_index,
    input  logic [7:0]  i_load_priority,
    input  logic [15:0] i_ready_mask,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_grant_valid,
    output logic [3:0]  o_grant_index,
    output logic [7:0]  o_grant_priority
);

    paa_pkg::t_cfg    r_cfg;
    logic             r_out_valid;
    paa_pkg::t_result r_out;

    logic             res_valid;
    logic             res_ready;
    paa_pkg::t_result res;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.age_limit <= 8'd5;
            r_cfg.prio_cap  <= 8'd255;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                paa_pkg::CFG_AGE_LIMIT: r_cfg.age_limit <= i_cfg_data;
                paa_pkg::CFG_PRIO_CAP:  r_cfg.prio_cap  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    paa_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_ready         (o_in_ready),
        .i_func          (i_func),
        .i_entry_index   (i_entry_index),
        .i_load_priority (i_load_priority),
        .i_ready_mask    (i_ready_mask),
        .i_cfg           (r_cfg),
        .o_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .o_res           (res)
    );

    // Output register: refills the same cycle it drains.
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                r_out_valid <= 1'b1;
                r_out       <= res;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_grant_valid    = r_out.found;
    assign o_grant_index    = 4'(r_out.index);
    assign o_grant_priority = r_out.prio;

endmodule
